[rtl/rsm_pkg.sv]
`timescale 1ns / 1ps

package rsm_pkg;

  localparam int unsigned LBA_W   = 32;
  localparam int unsigned STRIP_W = 16;
  localparam int unsigned DCFG_W  = 5;
  localparam int unsigned CNT_IN_W = 7;
  localparam int unsigned DID_W   = 4;

  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_FAIL    = 2'd2;
  localparam logic [1:0] REQ_RECOVER = 2'd3;

  localparam logic [1:0] CMD_READ        = 2'd0;
  localparam logic [1:0] CMD_WRITE       = 2'd1;
  localparam logic [1:0] CMD_FAIL_ACK    = 2'd2;
  localparam logic [1:0] CMD_RECOVER_ACK = 2'd3;

  localparam logic CFG_STRIP = 1'b0;
  localparam logic CFG_DISKS = 1'b1;

  typedef enum logic [2:0] {
    OP_WAIT_IN,
    OP_NOP,
    OP_DIV1_INIT,
    OP_DIV_STEP,
    OP_DIV2_INIT,
    OP_MUL,
    OP_EMIT,
    OP_ACK
  } op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_IS_ACK,
    C_EMPTY,
    C_DIV_MORE,
    C_MORE
  } cond_e;

  typedef logic [3:0] step_t;

  localparam step_t P_IDLE      = 4'd0;
  localparam step_t P_DISPATCH  = 4'd1;
  localparam step_t P_DIV1_INIT = 4'd2;
  localparam step_t P_DIV1_STEP = 4'd3;
  localparam step_t P_DIV2_INIT = 4'd4;
  localparam step_t P_DIV2_STEP = 4'd5;
  localparam step_t P_MUL       = 4'd6;
  localparam step_t P_EMIT      = 4'd7;
  localparam step_t P_DONE      = 4'd8;
  localparam step_t P_ACK       = 4'd9;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t tgt;
  } ctrl_word_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  function automatic ctrl_word_t rsm_ucode(step_t pc);
    ctrl_word_t cw;
    case (pc)
      P_IDLE:      cw = '{op: OP_WAIT_IN,   cond: C_NONE,     tgt: P_IDLE};
      P_DISPATCH:  cw = '{op: OP_NOP,       cond: C_IS_ACK,   tgt: P_ACK};
      P_DIV1_INIT: cw = '{op: OP_DIV1_INIT, cond: C_EMPTY,    tgt: P_IDLE};
      P_DIV1_STEP: cw = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, tgt: P_DIV1_STEP};
      P_DIV2_INIT: cw = '{op: OP_DIV2_INIT, cond: C_NONE,     tgt: P_IDLE};
      P_DIV2_STEP: cw = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, tgt: P_DIV2_STEP};
      P_MUL:       cw = '{op: OP_MUL,       cond: C_NONE,     tgt: P_IDLE};
      P_EMIT:      cw = '{op: OP_EMIT,      cond: C_MORE,     tgt: P_EMIT};
      P_DONE:      cw = '{op: OP_NOP,       cond: C_ALWAYS,   tgt: P_IDLE};
      P_ACK:       cw = '{op: OP_ACK,       cond: C_ALWAYS,   tgt: P_IDLE};
      default:     cw = '{op: OP_NOP,       cond: C_ALWAYS,   tgt: P_IDLE};
    endcase
    return cw;
  endfunction

endpackage

[rtl/rsm_div.sv]
`timescale 1ns / 1ps

module rsm_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rsm_pkg::div_ctrl_t                  ctrl_i,
  input  logic [rsm_pkg::LBA_W-1:0]           dividend_i,
  input  logic [rsm_pkg::STRIP_W-1:0]         divisor_i,
  output logic [rsm_pkg::LBA_W-1:0]           quo_o,
  output logic [rsm_pkg::STRIP_W-1:0]         rem_o,
  output logic                                more_o
);
  import rsm_pkg::*;

  localparam int unsigned ITER_W = $clog2(LBA_W);

  logic [LBA_W-1:0]   quo_q;
  logic [STRIP_W-1:0] rem_q, dvs_q;
  logic [ITER_W-1:0]  iter_q;
  logic [STRIP_W:0]   shifted;
  logic [STRIP_W:0]   diff;
  logic               fits;

  // one restoring step per cycle while step is asserted
  always_comb begin
    shifted = {rem_q, quo_q[LBA_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (ctrl_i.load) begin
      iter_q <= ITER_W'(LBA_W - 1);
    end else if (ctrl_i.step && iter_q != '0) begin
      iter_q <= iter_q - ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (ctrl_i.step) begin
      quo_q <= {quo_q[LBA_W-2:0], fits};
      rem_q <= fits ? diff[STRIP_W-1:0] : shifted[STRIP_W-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign more_o = (iter_q != '0);

endmodule

[rtl/raid0_stripe_mapper.sv]
`timescale 1ns / 1ps

// RAID 0 stripe mapper. A read or write run (start block, count) becomes one
// disk command per block in ascending logical order; a fail request clears
// and a recover request sets a bit of the active-disk map, and either gives
// one acknowledgement. A run does two bit-serial divisions (start by strip
// size, then strip index by disk count) in one shared divider, a multiply,
// then one command per cycle while the output is not stalled. The control
// sequence is a small microcode table. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
module raid0_stripe_mapper #(
  parameter int unsigned MAX_DISKS = 16,
  parameter int unsigned MAX_RUN   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [rsm_pkg::STRIP_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic [rsm_pkg::LBA_W-1:0]         start_lba_i,
  input  logic [rsm_pkg::CNT_IN_W-1:0]      block_count_i,
  input  logic [rsm_pkg::LBA_W-1:0]         write_word_i,
  input  logic [rsm_pkg::DID_W-1:0]         disk_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        cmd_kind_o,
  output logic [rsm_pkg::DID_W-1:0]         disk_index_o,
  output logic [rsm_pkg::LBA_W-1:0]         disk_block_o,
  output logic [rsm_pkg::LBA_W-1:0]         data_word_o,
  output logic                              disk_failed_o,
  output logic                              wr_fault_o,
  output logic                              last_o
);
  import rsm_pkg::*;

  localparam int unsigned DISK_W = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int unsigned DC_W   = $clog2(MAX_DISKS + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_RUN + 1);

  // configuration
  logic [STRIP_W-1:0] strip_q;
  logic [DCFG_W-1:0]  dcfg_q;
  logic [STRIP_W-1:0] sb_eff;
  logic [DC_W-1:0]    dc_eff;

  // sequencer
  step_t      pc_q, pc_d;
  ctrl_word_t cw;
  logic       go, cond_hit, accept;

  // request
  logic [1:0]       req_q;
  logic [LBA_W-1:0] word_q;
  logic [DID_W-1:0] did_q;
  logic [CNT_W-1:0] left_q;
  logic [CNT_W-1:0] cnt_eff;

  // walk state
  logic [LBA_W-1:0]   pos_q, base_q;
  logic [STRIP_W-1:0] off_q;
  logic [DISK_W-1:0]  disk_q;
  logic               werr_q;

  logic [MAX_DISKS-1:0] active_q, active_d, ack_mask, run_mask;
  logic                 ack_failed, run_failed, is_write, is_last, werr_n;

  // divider
  div_ctrl_t          div_ctrl;
  logic [LBA_W-1:0]   div_dividend, div_quo;
  logic [STRIP_W-1:0] div_divisor, div_rem;
  logic               div_more;
  logic [47:0]        prod;

  // output slot
  logic       out_valid_q, slot_free, load_out;
  logic [1:0]         kind_q;
  logic [DID_W-1:0]   oidx_q;
  logic [LBA_W-1:0]   oblk_q, oword_q;
  logic               ofail_q, owerr_q, olast_q;

  always_comb begin
    sb_eff = (strip_q == '0) ? STRIP_W'(1) : strip_q;
    if (dcfg_q == '0) begin
      dc_eff = DC_W'(1);
    end else if (32'(dcfg_q) > MAX_DISKS) begin
      dc_eff = DC_W'(MAX_DISKS);
    end else begin
      dc_eff = DC_W'(dcfg_q);
    end
    if (32'(block_count_i) > MAX_RUN) begin
      cnt_eff = CNT_W'(MAX_RUN);
    end else begin
      cnt_eff = CNT_W'(block_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= STRIP_W'(1);
      dcfg_q  <= DCFG_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRIP: strip_q <= cfg_data_i;
        CFG_DISKS: dcfg_q  <= cfg_data_i[DCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // microcode sequencer
  assign slot_free = !out_valid_q || !out_stall_i;
  assign cw        = rsm_ucode(pc_q);

  always_comb begin
    case (cw.op)
      OP_WAIT_IN:      go = in_valid_i;
      OP_EMIT, OP_ACK: go = slot_free;
      default:         go = 1'b1;
    endcase
    case (cw.cond)
      C_NONE:     cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_IS_ACK:   cond_hit = req_q[1];
      C_EMPTY:    cond_hit = (left_q == '0);
      C_DIV_MORE: cond_hit = div_more;
      C_MORE:     cond_hit = (left_q != CNT_W'(1));
      default:    cond_hit = 1'b0;
    endcase
    if (!go) begin
      pc_d = pc_q;
    end else if (cond_hit) begin
      pc_d = cw.tgt;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= P_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_stall_o = (cw.op != OP_WAIT_IN);
  assign accept     = in_valid_i && (cw.op == OP_WAIT_IN);

  // shared divider
  always_comb begin
    div_ctrl.load = (cw.op == OP_DIV1_INIT) || (cw.op == OP_DIV2_INIT);
    div_ctrl.step = (cw.op == OP_DIV_STEP);
    if (cw.op == OP_DIV1_INIT) begin
      div_dividend = pos_q;
      div_divisor  = sb_eff;
    end else begin
      div_dividend = div_quo;
      div_divisor  = STRIP_W'(dc_eff);
    end
  end

  rsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .more_o     (div_more)
  );

  assign prod = 48'(div_quo) * 48'(sb_eff);

  // active map and failure lookup
  always_comb begin
    ack_mask = MAX_DISKS'(1) << did_q;
    run_mask = MAX_DISKS'(1) << disk_q;
    if (req_q == REQ_FAIL) begin
      active_d = active_q & ~ack_mask;
    end else begin
      active_d = active_q | ack_mask;
    end
    ack_failed = |(ack_mask & ~active_d);
    run_failed = |(run_mask & ~active_q);
    is_write   = (req_q == REQ_WRITE);
    is_last    = (left_q == CNT_W'(1));
    werr_n     = werr_q || (is_write && run_failed);
  end

  assign load_out = go && ((cw.op == OP_EMIT) || (cw.op == OP_ACK));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '1;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      werr_q      <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        left_q <= cnt_eff;
        werr_q <= 1'b0;
      end else if (go && cw.op == OP_EMIT) begin
        left_q <= left_q - CNT_W'(1);
        werr_q <= werr_n;
      end
      if (go && cw.op == OP_ACK) begin
        active_q <= active_d;
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      word_q <= write_word_i;
      did_q  <= disk_id_i;
      pos_q  <= start_lba_i;
    end
    case (cw.op)
      OP_DIV2_INIT: off_q <= div_rem;
      OP_MUL: begin
        disk_q <= DISK_W'(div_rem);
        base_q <= prod[LBA_W-1:0];
      end
      OP_EMIT: begin
        if (go) begin
          pos_q <= pos_q + LBA_W'(1);
          if (pos_q == '1) begin
            off_q  <= '0;
            disk_q <= '0;
            base_q <= '0;
          end else if ({1'b0, off_q} + 17'(1) == {1'b0, sb_eff}) begin
            off_q <= '0;
            if (32'(disk_q) + 32'(1) == 32'(dc_eff)) begin
              disk_q <= '0;
              base_q <= base_q + LBA_W'(sb_eff);
            end else begin
              disk_q <= disk_q + DISK_W'(1);
            end
          end else begin
            off_q <= off_q + STRIP_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (cw.op == OP_ACK) begin
        kind_q  <= (req_q == REQ_FAIL) ? CMD_FAIL_ACK : CMD_RECOVER_ACK;
        oidx_q  <= did_q;
        oblk_q  <= '0;
        oword_q <= '0;
        ofail_q <= ack_failed;
        owerr_q <= 1'b0;
        olast_q <= 1'b1;
      end else begin
        kind_q  <= is_write ? CMD_WRITE : CMD_READ;
        oidx_q  <= DID_W'(disk_q);
        oblk_q  <= base_q + LBA_W'(off_q);
        oword_q <= is_write ? word_q : '0;
        ofail_q <= run_failed;
        owerr_q <= is_write && is_last && werr_n;
        olast_q <= is_last;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_kind_o    = kind_q;
  assign disk_index_o  = oidx_q;
  assign disk_block_o  = oblk_q;
  assign data_word_o   = oword_q;
  assign disk_failed_o = ofail_q;
  assign wr_fault_o    = owerr_q;
  assign last_o        = olast_q;

endmodule
